/* rtl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sftl_pkg.sv */
package sftl_pkg;

  localparam int MAX_FRAMES_DEF = 64;
  localparam int HIT_IDX_W      = 8;
  localparam int FRAME_IDX_W    = 6;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_FIRST = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_LOOP   = 2'd0,
    REG_TEX_W  = 2'd1,
    REG_TEX_H  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [31:0]        dur;
    logic               col;
  } entry_t;

  // Search wavefront handed from cell to cell.
  typedef struct packed {
    logic                 active;
    logic                 found;
    logic [31:0]          start;
    logic [31:0]          t;
    logic [HIT_IDX_W-1:0] idx;
    entry_t               hit;
  } wave_t;

endpackage

/* rtl/sftl_cell.sv */
module sftl_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [CNT_W-1:0]        wr_idx,
  input  sftl_pkg::entry_t        wr_entry,
  input  logic [CNT_W-1:0]        count,
  input  sftl_pkg::wave_t         wave_in,
  output sftl_pkg::wave_t         wave_out,
  output sftl_pkg::entry_t        entry
);
  import sftl_pkg::*;

  entry_t      stored;
  wave_t       wave_next;
  logic [31:0] frame_end;

  // Entry storage, written once when the table grows to this slot.
  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == CNT_W'(IDX)) begin
      stored <= wr_entry;
    end
  end

  assign entry = stored;

  // Test this frame's window and pass the wavefront on.
  always_comb begin
    frame_end = wave_in.start + stored.dur;
    wave_next = wave_in;
    wave_next.start = frame_end;
    if (wave_in.active && !wave_in.found && CNT_W'(IDX) < count &&
        wave_in.start <= wave_in.t && wave_in.t <= frame_end) begin
      wave_next.found = 1'b1;
      wave_next.idx   = HIT_IDX_W'(IDX);
      wave_next.hit   = stored;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.active <= 1'b0;
    end else begin
      wave_out.active <= wave_next.active;
    end
    wave_out.found <= wave_next.found;
    wave_out.start <= wave_next.start;
    wave_out.t     <= wave_next.t;
    wave_out.idx   <= wave_next.idx;
    wave_out.hit   <= wave_next.hit;
  end

endmodule

/* rtl/sftl_mod.sv */
module sftl_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] rem
);
  logic        busy;
  logic [31:0] quo;
  logic [5:0]  cnt;
  logic [32:0] trial;

  // One restoring step per cycle, remainder only.
  assign trial = {rem, quo[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        cnt  <= 6'd32;
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= 32'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[31:0];
        end
        quo <= {quo[30:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/sprite_frame_timeline_lookup.sv */
// Sprite frame timeline lookup. Frames live in a chain of MAX_FRAMES cells, one
// frame per cell. Add and first-frame items go from idle straight to the done
// state. A query by elapsed time sends a wavefront down the chain, one cell per
// cycle, after a pass through the 32-step modulo unit when looping is on. One
// item is in flight at a time; a finished result waits in the output register
// while the next item is taken.
module sprite_frame_timeline_lookup #(
  parameter int MAX_FRAMES = sftl_pkg::MAX_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic signed [15:0] crop_u,
  input  logic signed [15:0] crop_v,
  input  logic signed [15:0] crop_width,
  input  logic signed [15:0] crop_height,
  input  logic [31:0]        duration,
  input  logic               collidable,
  input  logic [31:0]        elapsed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               ok,
  output logic [5:0]         frame_index,
  output logic signed [15:0] out_u,
  output logic signed [15:0] out_v,
  output logic signed [15:0] out_width,
  output logic signed [15:0] out_height,
  output logic [31:0]        out_duration,
  output logic               out_collidable,
  output logic               any_collidable,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import sftl_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_WALK, S_DONE} state_t;

  state_t           state;
  logic             loop_enable;
  logic [15:0]      texture_width;
  logic [15:0]      texture_height;
  logic [CNT_W-1:0] frame_count;
  logic [31:0]      total_duration;
  logic             collidable_seen;

  logic             pend_ok;
  logic [5:0]       pend_idx;
  entry_t           pend_entry;

  wave_t            waves [0:MAX_FRAMES];
  entry_t           entries [0:MAX_FRAMES-1];
  logic             launch_active;
  logic [31:0]      launch_t;
  logic             wr_en;
  entry_t           new_entry;
  logic             add_ok;
  logic signed [16:0] u_end;
  logic signed [16:0] v_end;
  logic             query_go;
  logic             direct_go;
  logic             mod_start;
  logic             mod_done;
  logic [31:0]      mod_rem;
  logic             in_fire;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  // Crop bounds, texture size and table space check for an add beat.
  assign u_end = 17'(crop_u) + 17'(crop_width);
  assign v_end = 17'(crop_v) + 17'(crop_height);
  assign add_ok = texture_width != 16'd0 && texture_height != 16'd0 &&
                  !crop_u[15] && !crop_v[15] &&
                  u_end <= $signed({1'b0, texture_width}) &&
                  v_end <= $signed({1'b0, texture_height}) &&
                  frame_count < CNT_W'(MAX_FRAMES);
  assign new_entry = '{u: crop_u, v: crop_v, w: crop_width, h: crop_height,
                       dur: duration, col: collidable};
  assign wr_en = in_fire && kind == KIND_ADD && add_ok;

  // A query goes through the modulo unit, straight down the chain, or neither when refused.
  assign query_go  = in_fire && kind == KIND_QUERY && frame_count != '0 &&
                     total_duration != '0;
  assign mod_start = query_go && loop_enable;
  assign direct_go = query_go && !loop_enable && elapsed < total_duration;

  sftl_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (elapsed),
    .divisor  (total_duration),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Wavefront launch into the first cell.
  assign waves[0] = '{active: launch_active, found: 1'b0, start: '0, t: launch_t,
                      idx: '0, hit: '0};

  // Row of frame cells.
  for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
    sftl_cell #(.IDX(k), .CNT_W(CNT_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en),
      .wr_idx   (frame_count),
      .wr_entry (new_entry),
      .count    (frame_count),
      .wave_in  (waves[k]),
      .wave_out (waves[k+1]),
      .entry    (entries[k])
    );
  end

  // Control, table totals, configuration and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      loop_enable     <= 1'b1;
      texture_width   <= '0;
      texture_height  <= '0;
      frame_count     <= '0;
      total_duration  <= '0;
      collidable_seen <= 1'b0;
      out_valid       <= 1'b0;
      launch_active   <= 1'b0;
    end else begin
      launch_active <= direct_go || (state == S_MOD && mod_done);
      if (direct_go) begin
        launch_t <= elapsed;
      end else if (state == S_MOD && mod_done) begin
        launch_t <= mod_rem;
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOOP:  loop_enable    <= cfg_data[0];
          REG_TEX_W: texture_width  <= cfg_data;
          REG_TEX_H: texture_height <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (wr_en) begin
              pend_ok    <= 1'b1;
              pend_idx   <= frame_count[FRAME_IDX_W-1:0];
              pend_entry <= new_entry;
            end else if (kind == KIND_FIRST && frame_count != '0) begin
              pend_ok    <= 1'b1;
              pend_idx   <= '0;
              pend_entry <= entries[0];
            end else begin
              pend_ok    <= 1'b0;
              pend_idx   <= '0;
              pend_entry <= '0;
            end
            if (wr_en) begin
              frame_count     <= frame_count + CNT_W'(1);
              total_duration  <= total_duration + duration;
              collidable_seen <= collidable_seen | collidable;
            end
            if (mod_start) begin
              state <= S_MOD;
            end else if (direct_go) begin
              state <= S_WALK;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (waves[MAX_FRAMES].active) begin
            if (waves[MAX_FRAMES].found) begin
              pend_ok    <= 1'b1;
              pend_idx   <= waves[MAX_FRAMES].idx[FRAME_IDX_W-1:0];
              pend_entry <= waves[MAX_FRAMES].hit;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            ok             <= pend_ok;
            frame_index    <= pend_idx;
            out_u          <= pend_entry.u;
            out_v          <= pend_entry.v;
            out_width      <= pend_entry.w;
            out_height     <= pend_entry.h;
            out_duration   <= pend_entry.dur;
            out_collidable <= pend_entry.col;
            any_collidable <= collidable_seen;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/sftl_checker.sv */
module sftl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        ok,
  input logic [5:0]  frame_index,
  input logic [31:0] out_duration
);
`include "assert_macros.svh"

  // A stalled result beat keeps its payload.
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(frame_index), "result beat changed while stalled")

  // Nothing comes out right after reset.
  `ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "result beat during reset")

  // A miss or reject carries a zeroed payload.
  `ASSERT_CLK(a_miss_zero, clk, rst, out_valid && !ok |-> frame_index == 6'd0 && out_duration == 32'd0, "nonzero payload on miss")

  // One item at a time: after an input beat the block is busy.
  `ASSERT_CLK(a_busy, clk, rst, in_valid && in_ready |=> !in_ready, "input taken while busy")

endmodule

bind sprite_frame_timeline_lookup sftl_checker u_sftl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .ok           (ok),
  .frame_index  (frame_index),
  .out_duration (out_duration)
);

/* test/sprite_frame_timeline_lookup_test.sv */
module sprite_frame_timeline_lookup_test;
  import sftl_pkg::*;

  localparam int FRAMES = MAX_FRAMES_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int CALM_FROM = 20000;
  localparam int CALM_TO = 40000;
  localparam int HOLD_AT = 60000;
  localparam int HOLD_LEN = 400;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [31:0]        dur;
    logic               col;
    logic [31:0]        elapsed;
  } frame_req_t;

  typedef struct packed {
    logic               ok;
    logic [5:0]         idx;
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [31:0]        dur;
    logic               col;
    logic               any_col;
  } frame_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic signed [15:0] crop_u = '0, crop_v = '0, crop_width = '0, crop_height = '0;
  logic [31:0] duration = '0, elapsed = '0;
  logic collidable = 1'b0;
  logic out_valid, out_ready = 1'b0;
  logic ok, out_collidable, any_collidable;
  logic [5:0] frame_index;
  logic signed [15:0] out_u, out_v, out_width, out_height;
  logic [31:0] out_duration;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sprite_frame_timeline_lookup u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the block state and its registers.
  entry_t      shadow_frames [FRAMES];
  int unsigned shadow_count;
  logic [31:0] shadow_total;
  logic        shadow_any_col;
  logic        shadow_loop;
  logic [15:0] shadow_tex_w, shadow_tex_h;

  frame_req_t  pending_q[$];
  frame_resp_t expected_q[$];
  frame_req_t  cur_req;
  bit          req_taken = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  int          error_count = 0;

  function automatic frame_resp_t frame_hit(int unsigned k);
    frame_resp_t r;
    r = '0;
    r.ok = 1'b1;
    r.idx = k[5:0];
    r.u = shadow_frames[k].u;
    r.v = shadow_frames[k].v;
    r.w = shadow_frames[k].w;
    r.h = shadow_frames[k].h;
    r.dur = shadow_frames[k].dur;
    r.col = shadow_frames[k].col;
    return r;
  endfunction

  // Applies one beat to the shadow state and returns the expected result.
  function automatic frame_resp_t lookup_frame(frame_req_t q);
    frame_resp_t r;
    logic [31:0] t, start, fin;
    bit fits;
    r = '0;
    case (q.kind)
      KIND_ADD: begin
        fits = shadow_tex_w != 0 && shadow_tex_h != 0 && q.u >= 0 && q.v >= 0
          && (32'(q.u) + 32'(q.w)) <= $signed({16'd0, shadow_tex_w})
          && (32'(q.v) + 32'(q.h)) <= $signed({16'd0, shadow_tex_h})
          && shadow_count < FRAMES;
        if (fits) begin
          shadow_frames[shadow_count] = '{q.u, q.v, q.w, q.h, q.dur, q.col};
          if (q.col) shadow_any_col = 1'b1;
          shadow_total += q.dur;
          r = frame_hit(shadow_count);
          shadow_count++;
        end
      end
      KIND_QUERY: begin
        if (shadow_count > 0 && shadow_total != 0) begin
          t = q.elapsed;
          if (shadow_loop) t = t % shadow_total;
          if (t < shadow_total) begin
            start = 0;
            for (int k = 0; k < shadow_count; k++) begin
              fin = start + shadow_frames[k].dur;
              if (start <= t && t <= fin) begin
                r = frame_hit(k);
                break;
              end
              start = fin;
            end
          end
        end
      end
      KIND_FIRST: begin
        if (shadow_count > 0) r = frame_hit(0);
      end
      default: ;
    endcase
    r.any_col = shadow_any_col;
    return r;
  endfunction

  // Driver: offers queued beats at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 0;
      if (pending_q.size() > 0 &&
          ((cycle_count >= CALM_FROM && cycle_count < CALM_TO) ||
           $urandom_range(99) >= 22)) begin
        cur_req = pending_q.pop_front();
        in_valid <= 1'b1;
        kind <= cur_req.kind;
        crop_u <= cur_req.u;
        crop_v <= cur_req.v;
        crop_width <= cur_req.w;
        crop_height <= cur_req.h;
        duration <= cur_req.dur;
        collidable <= cur_req.col;
        elapsed <= cur_req.elapsed;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back the block up.
  always @(negedge clk) begin
    if (cycle_count == HOLD_AT) hold_left = HOLD_LEN;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (cycle_count >= CALM_FROM && cycle_count < CALM_TO) ||
                   $urandom_range(99) >= 22;
    end
  end

  // Monitor: predicts on accepted inputs, checks accepted results.
  always @(posedge clk) begin
    frame_resp_t got, want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOOP:  shadow_loop = cfg_data[0];
          REG_TEX_W: shadow_tex_w = cfg_data;
          REG_TEX_H: shadow_tex_h = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{ok, frame_index, out_u, out_v, out_width, out_height,
                out_duration, out_collidable, any_collidable};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_q = {expected_q, lookup_frame(cur_req)};
        req_taken = 1;
      end
    end
  end

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_item(logic [1:0] k, int u, int v, int w, int h,
                           logic [31:0] dur, int col, logic [31:0] t);
    frame_req_t req;
    req = '{k, 16'(u), 16'(v), 16'(w), 16'(h), dur, 1'(col), t};
    pending_q = {pending_q, req};
  endtask

  // Elapsed time near a cumulative frame boundary of the current table.
  function automatic logic [31:0] boundary_time();
    logic [31:0] acc;
    int n;
    acc = 0;
    if (shadow_count == 0) return $urandom_range(3);
    n = $urandom_range(shadow_count - 1);
    for (int k = 0; k <= n; k++) acc += shadow_frames[k].dur;
    return acc + 32'($urandom_range(2)) - 32'd1;
  endfunction

  task automatic random_item();
    int roll, tw, th, u, v;
    roll = $urandom_range(99);
    tw = int'(shadow_tex_w);
    th = int'(shadow_tex_h);
    if (roll < 15) begin
      // Well-formed add whose crop mostly stays inside the texture.
      u = $urandom_range(tw);
      v = $urandom_range(th);
      push_item(KIND_ADD, u, v, $urandom_range(tw - u), $urandom_range(th - v),
                ($urandom_range(19) == 0) ? $urandom : $urandom_range(40),
                int'($urandom_range(9) == 0), $urandom);
    end else if (roll < 22) begin
      push_item(KIND_ADD, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(1), $urandom);
    end else if (roll < 60) begin
      push_item(KIND_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(1), boundary_time());
    end else if (roll < 80) begin
      push_item(KIND_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(1), $urandom);
    end else if (roll < 93) begin
      push_item(KIND_FIRST, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(1), $urandom);
    end else begin
      push_item(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(1), $urandom);
    end
  endtask

  initial begin
    logic [15:0] sizes [4];
    shadow_count = 0;
    shadow_total = 0;
    shadow_any_col = 1'b0;
    shadow_loop = 1'b1;
    shadow_tex_w = 0;
    shadow_tex_h = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty table and no texture: every query misses and every add is refused.
    push_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0);
    push_item(KIND_FIRST, 0, 0, 0, 0, 0, 0, 0);
    push_item(KIND_ADD, 0, 0, 1, 1, 5, 1, 0);
    push_item(KIND_UNUSED, 0, 0, 0, 0, 0, 0, 0);
    wait_idle();
    write_reg(REG_TEX_W, 16'd100);
    push_item(KIND_ADD, 0, 0, 1, 1, 5, 1, 0);
    wait_idle();
    write_reg(REG_TEX_H, 16'd50);

    // Zero-duration frame gives a zero total, then crop edges.
    push_item(KIND_ADD, 0, 0, 100, 50, 0, 0, 0);
    push_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 5);
    push_item(KIND_ADD, -1, 0, 1, 1, 7, 1, 0);
    push_item(KIND_ADD, 0, -32768, 1, 1, 7, 1, 0);
    push_item(KIND_ADD, 1, 0, 100, 1, 7, 1, 0);
    push_item(KIND_ADD, 0, 1, 1, 50, 7, 1, 0);
    push_item(KIND_ADD, 32767, 0, -32768, -32768, 10, 1, 0);
    push_item(KIND_ADD, 0, 0, -32768, 32767, 10, 1, 0);
    push_item(KIND_FIRST, 0, 0, 0, 0, 0, 0, 0);
    push_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0);
    push_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 10);
    push_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 11);
    push_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    wait_idle();
    write_reg(REG_LOOP, 16'd0);
    push_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 9);
    push_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 10);
    push_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    // A huge duration wraps the total.
    push_item(KIND_ADD, 0, 0, 1, 1, 32'hFFFF_FFFF, 0, 0);
    push_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 8);
    wait_idle();

    // Random phases, each with its register settings written anew.
    sizes = '{16'd1, 16'd65535, 16'd0, 16'd200};
    for (int p = 0; p < 7; p++) begin
      write_reg(REG_LOOP, p[0] ? 16'd0 : 16'd1);
      write_reg(REG_TEX_W, (p == 0) ? 16'd65535 : sizes[$urandom_range(3)] |
                           16'($urandom_range(p == 5 ? 0 : 1) * $urandom_range(300)));
      write_reg(REG_TEX_H, (p == 0) ? 16'd65535 : sizes[$urandom_range(3)]);
      repeat (260) random_item();
      wait_idle();
    end

    if (error_count == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
